// File: rtl/core/wmn_pkg.sv
package wmn_pkg;

   // Store and price geometry.
   localparam int WINDOW_DEPTH = 32;
   localparam int PRICE_BITS   = 32;
   localparam int PRICE_W      = 32;
   localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
   localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int ROW_W        = 2 * PRICE_BITS + 1;

   // Signed Q8.16 result format.
   localparam int FRAC_BITS = 16;
   localparam int INT_BITS  = 8;
   localparam int QUO_BITS  = FRAC_BITS + INT_BITS;
   localparam int NORM_W    = QUO_BITS + 1;
   localparam int STEP_W    = $clog2(QUO_BITS + 1);

   localparam logic [NORM_W-1:0] POS_SAT = {1'b0, {(NORM_W - 1){1'b1}}};
   localparam logic [NORM_W-1:0] NEG_SAT = {1'b1, {(NORM_W - 1){1'b0}}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic row_load;
      logic range_latch;
      logic rd_issue;
      logic row_latch;
      logic div_start;
      logic div_sel_low;
      logic high_latch;
      logic low_latch;
      logic out_load;
      logic idx_next;
      logic window_clear;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic flat;
      logic idx_last;
      logic div_done;
   } dp_status_type;

endpackage

// File: rtl/core/window_minmax_normalizer.sv
// Window min-max normaliser.
// The req channel takes one price row per word: high price, low price, a
// target flag and a last-row flag. Rows load at one word per cycle; feature
// rows update the running maximum high and minimum low, target rows are only
// stored. Rows arriving with the store full are dropped and mark the window.
// The word flagged last closes the window; req_ready then falls and the
// stored rows are sent on the rsp channel in arrival order, each word holding
// (high-min)/range and (low-min)/range as saturated signed Q8.16 values.
// The two quotients of a row share one restoring divider, and each goes
// through start, set-up, 24 one-bit steps and capture. Each row is read
// from the store, latched, divided for its high and then its low, and
// loaded into the rsp word. A saturating quotient skips the one-bit steps,
// and a flat window skips the divider. The window is cleared in the cycle
// after its last word is taken, and req_ready is high from the cycle after
// that. A stalled receiver simply holds the current rsp word; nothing is lost
// or repeated. Reset is synchronous and leaves an empty window with req_ready
// high.
module window_minmax_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wmn_pkg::PRICE_W-1:0]       req_price_high,
   input  logic [wmn_pkg::PRICE_W-1:0]       req_price_low,
   input  logic                              req_is_target,
   input  logic                              req_last_row,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [wmn_pkg::NORM_W-1:0] rsp_norm_high,
   output logic signed [wmn_pkg::NORM_W-1:0] rsp_norm_low,
   output logic                              rsp_target_row,
   output logic                              rsp_flat_range,
   output logic                              rsp_overflow,
   output logic                              rsp_last_out
);

   import wmn_pkg::*;

   // Command and status bundles between the sequencer and the datapath.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller owns both handshakes and steps through load, range
   // set-up and the per-row read, divide and emit sequence.
   wmn_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_last_row),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   // The datapath holds the row store, window extremes, the shared divider
   // and the registered rsp word, which stays stable while it waits.
   wmn_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_price_high (req_price_high),
      .req_price_low  (req_price_low),
      .req_is_target  (req_is_target),
      .rsp_norm_high  (rsp_norm_high),
      .rsp_norm_low   (rsp_norm_low),
      .rsp_target_row (rsp_target_row),
      .rsp_flat_range (rsp_flat_range),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_out   (rsp_last_out)
   );

endmodule

// File: rtl/core/wmn_ram.sv
module wmn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/wmn_div.sv
module wmn_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wmn_pkg::PRICE_BITS-1:0]      value,
   input  logic [wmn_pkg::PRICE_BITS-1:0]      minimum,
   input  logic [wmn_pkg::PRICE_BITS-1:0]      range_mag,
   input  logic                                range_neg,
   output logic                                done,
   output logic signed [wmn_pkg::NORM_W-1:0]   result
);

   import wmn_pkg::*;

   logic [PRICE_BITS-1:0] dmag_ff, dmag_in;
   logic [PRICE_BITS-1:0] rmag_ff, rmag_in;
   logic [PRICE_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  neg_ff, neg_in;
   logic                  sat_ff, sat_in;
   logic                  setup_ff, setup_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [PRICE_BITS:0]   trial;
   logic                  ge;
   logic [NORM_W-1:0]     mag;

   // Restoring division of (|x - min| << 16) by the range, one quotient bit a cycle.
   // The integer part is checked against 256 first, so 24 bits always suffice.
   always_comb begin
      dmag_in  = dmag_ff;
      rmag_in  = rmag_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      setup_in = 1'b0;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[QUO_BITS-1]};
      ge       = trial >= {1'b0, rmag_ff};
      if (start) begin
         if (value < minimum) begin
            dmag_in = minimum - value;
         end else begin
            dmag_in = value - minimum;
         end
         neg_in   = (value < minimum) != range_neg;
         rmag_in  = range_mag;
         setup_in = 1'b1;
      end else if (setup_ff) begin
         sat_in  = {{INT_BITS{1'b0}}, dmag_ff} >= {rmag_ff, {INT_BITS{1'b0}}};
         rem_in  = dmag_ff >> INT_BITS;
         quo_in  = {dmag_ff[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
         step_in = STEP_W'(QUO_BITS);
         run_in  = !sat_in;
         done_in = sat_in;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = PRICE_BITS'(trial - {1'b0, rmag_ff});
         end else begin
            rem_in = trial[PRICE_BITS-1:0];
         end
         quo_in  = {quo_ff[QUO_BITS-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff <= 1'b0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         setup_ff <= setup_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff <= dmag_in;
      rmag_ff <= rmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
   end

   assign mag  = {1'b0, quo_ff};
   assign done = done_ff;

   always_comb begin
      if (sat_ff) begin
         result = neg_ff ? NEG_SAT : POS_SAT;
      end else if (neg_ff) begin
         result = NORM_W'(0) - mag;
      end else begin
         result = mag;
      end
   end

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> !(setup_ff || run_ff))
      else $error("divider started while busy");

   a_done_not_running : assert property (@(posedge clock) disable iff (reset)
      !(run_ff && done_ff))
      else $error("divider reports done while still iterating");

endmodule

// File: rtl/core/wmn_dp.sv
module wmn_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  wmn_pkg::ctrl_cmd_type             cmd,
   output wmn_pkg::dp_status_type            status,
   input  logic [wmn_pkg::PRICE_W-1:0]       req_price_high,
   input  logic [wmn_pkg::PRICE_W-1:0]       req_price_low,
   input  logic                              req_is_target,
   output logic signed [wmn_pkg::NORM_W-1:0] rsp_norm_high,
   output logic signed [wmn_pkg::NORM_W-1:0] rsp_norm_low,
   output logic                              rsp_target_row,
   output logic                              rsp_flat_range,
   output logic                              rsp_overflow,
   output logic                              rsp_last_out
);

   import wmn_pkg::*;

   logic [PRICE_BITS-1:0] price_high, price_low;
   logic                  room, store_en, idx_last;
   logic [ROW_W-1:0]      rd_data;
   logic [PRICE_BITS-1:0] div_value;
   logic                  div_done;
   logic [NORM_W-1:0]     div_result;

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [PRICE_BITS-1:0] max_ff, max_in, min_ff, min_in;
   logic                  seen_ff, seen_in, dropped_ff, dropped_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [PRICE_BITS-1:0] rmag_ff, rmag_in;
   logic                  rneg_ff, rneg_in, flat_ff, flat_in;
   logic [PRICE_BITS-1:0] row_high_ff, row_high_in, row_low_ff, row_low_in;
   logic                  row_kind_ff, row_kind_in;
   logic [NORM_W-1:0]     norm_high_ff, norm_high_in, norm_low_ff, norm_low_in;
   logic                  target_ff, target_in, flat_out_ff, flat_out_in;
   logic                  overflow_ff, overflow_in, last_ff, last_in;

   assign price_high = PRICE_BITS'(req_price_high);
   assign price_low  = PRICE_BITS'(req_price_low);
   assign room       = count_ff < COUNT_W'(WINDOW_DEPTH);
   assign store_en   = cmd.row_load && room;
   assign idx_last   = (COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff;
   assign div_value  = cmd.div_sel_low ? row_low_ff : row_high_ff;

   // Row store laid out as {kind, low, high}.
   wmn_ram #(
      .WIDTH (ROW_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_is_target, price_low, price_high}),
      .rd_en   (cmd.rd_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   wmn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .value     (div_value),
      .minimum   (min_ff),
      .range_mag (rmag_ff),
      .range_neg (rneg_ff),
      .done      (div_done),
      .result    (div_result)
   );

   always_comb begin
      count_in     = count_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      seen_in      = seen_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      rmag_in      = rmag_ff;
      rneg_in      = rneg_ff;
      flat_in      = flat_ff;
      row_high_in  = row_high_ff;
      row_low_in   = row_low_ff;
      row_kind_in  = row_kind_ff;
      norm_high_in = norm_high_ff;
      norm_low_in  = norm_low_ff;
      target_in    = target_ff;
      flat_out_in  = flat_out_ff;
      overflow_in  = overflow_ff;
      last_in      = last_ff;

      if (cmd.window_clear) begin
         count_in   = '0;
         max_in     = '0;
         min_in     = '1;
         seen_in    = 1'b0;
         dropped_in = 1'b0;
      end else if (cmd.row_load) begin
         if (room) begin
            count_in = count_ff + COUNT_W'(1);
            if (!req_is_target) begin
               if (price_high > max_ff) begin
                  max_in = price_high;
               end
               if (price_low < min_ff) begin
                  min_in = price_low;
               end
               seen_in = 1'b1;
            end
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (cmd.range_latch) begin
         rneg_in = max_ff < min_ff;
         rmag_in = (max_ff < min_ff) ? (min_ff - max_ff) : (max_ff - min_ff);
         flat_in = !seen_ff || (max_ff == min_ff);
         idx_in  = '0;
      end

      if (cmd.idx_next) begin
         idx_in = idx_ff + ADDR_W'(1);
      end

      if (cmd.row_latch) begin
         row_high_in = rd_data[PRICE_BITS-1:0];
         row_low_in  = rd_data[2*PRICE_BITS-1:PRICE_BITS];
         row_kind_in = rd_data[ROW_W-1];
      end

      if (cmd.high_latch) begin
         norm_high_in = div_result;
      end
      if (cmd.low_latch) begin
         norm_low_in = div_result;
      end

      if (cmd.out_load) begin
         if (flat_ff) begin
            norm_high_in = '0;
            norm_low_in  = '0;
         end
         target_in   = row_kind_ff;
         flat_out_in = flat_ff;
         overflow_in = dropped_ff;
         last_in     = idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         max_ff     <= '0;
         min_ff     <= '1;
         seen_ff    <= 1'b0;
         dropped_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         seen_ff    <= seen_in;
         dropped_ff <= dropped_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rmag_ff      <= rmag_in;
      rneg_ff      <= rneg_in;
      flat_ff      <= flat_in;
      row_high_ff  <= row_high_in;
      row_low_ff   <= row_low_in;
      row_kind_ff  <= row_kind_in;
      norm_high_ff <= norm_high_in;
      norm_low_ff  <= norm_low_in;
      target_ff    <= target_in;
      flat_out_ff  <= flat_out_in;
      overflow_ff  <= overflow_in;
      last_ff      <= last_in;
   end

   assign status.count_zero = count_ff == '0;
   assign status.flat       = flat_ff;
   assign status.idx_last   = idx_last;
   assign status.div_done   = div_done;

   assign rsp_norm_high  = norm_high_ff;
   assign rsp_norm_low   = norm_low_ff;
   assign rsp_target_row = target_ff;
   assign rsp_flat_range = flat_out_ff;
   assign rsp_overflow   = overflow_ff;
   assign rsp_last_out   = last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WINDOW_DEPTH))
      else $error("row count beyond store depth");

endmodule

// File: rtl/core/wmn_ctrl.sv
module wmn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_row,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wmn_pkg::ctrl_cmd_type  cmd,
   input  wmn_pkg::dp_status_type status
);

   import wmn_pkg::*;

   typedef enum logic [3:0] {
      LOAD,
      PREP,
      READ,
      LATCH,
      START_H,
      DIV_H,
      START_L,
      DIV_L,
      FINISH,
      EMIT,
      CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;
   logic      accept;

   assign accept = req_valid && req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         LOAD: begin
            cmd.row_load = accept;
            if (accept && req_last_row) begin
               state_in = PREP;
            end
         end
         PREP: begin
            cmd.range_latch = 1'b1;
            state_in = status.count_zero ? CLEAR : READ;
         end
         READ: begin
            cmd.rd_issue = 1'b1;
            state_in = LATCH;
         end
         LATCH: begin
            cmd.row_latch = 1'b1;
            state_in = status.flat ? FINISH : START_H;
         end
         START_H: begin
            cmd.div_start = 1'b1;
            state_in = DIV_H;
         end
         DIV_H: begin
            if (status.div_done) begin
               cmd.high_latch = 1'b1;
               state_in = START_L;
            end
         end
         START_L: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_low = 1'b1;
            state_in = DIV_L;
         end
         DIV_L: begin
            cmd.div_sel_low = 1'b1;
            if (status.div_done) begin
               cmd.low_latch = 1'b1;
               state_in = FINISH;
            end
         end
         FINISH: begin
            cmd.out_load = 1'b1;
            state_in = EMIT;
         end
         EMIT: begin
            if (rsp_ready) begin
               if (status.idx_last) begin
                  state_in = CLEAR;
               end else begin
                  cmd.idx_next = 1'b1;
                  state_in = READ;
               end
            end
         end
         CLEAR: begin
            cmd.window_clear = 1'b1;
            state_in = LOAD;
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= state_in == LOAD;
         rsp_valid_ff <= state_in == EMIT;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_phases_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("loading and emitting at the same time");

   a_close_stops_load : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff && req_last_row) |=> !req_ready_ff)
      else $error("rows still taken after the window was closed");

endmodule

// File: tb/tb_window_minmax_normalizer.sv
module tb_window_minmax_normalizer;
   import wmn_pkg::*;

   // One rsp word as the block presents it, in port order.
   typedef struct packed {
      logic signed [NORM_W-1:0] high_q;
      logic signed [NORM_W-1:0] low_q;
      logic                     target;
      logic                     flat;
      logic                     dropped;
      logic                     closes;
   } norm_word_type;

   // Receiver behaviour; each mode holds for a random stretch of cycles.
   typedef enum int unsigned {
      RX_STREAM,
      RX_ALTERNATE,
      RX_RANDOM,
      RX_THROTTLE
   } rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [PRICE_W-1:0]       req_price_high = '0;
   logic [PRICE_W-1:0]       req_price_low = '0;
   logic                     req_is_target = 1'b0;
   logic                     req_last_row = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [NORM_W-1:0] rsp_norm_high;
   logic signed [NORM_W-1:0] rsp_norm_low;
   logic                     rsp_target_row;
   logic                     rsp_flat_range;
   logic                     rsp_overflow;
   logic                     rsp_last_out;

   window_minmax_normalizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_price_high (req_price_high),
      .req_price_low  (req_price_low),
      .req_is_target  (req_is_target),
      .req_last_row   (req_last_row),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_norm_high  (rsp_norm_high),
      .rsp_norm_low   (rsp_norm_low),
      .rsp_target_row (rsp_target_row),
      .rsp_flat_range (rsp_flat_range),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_out   (rsp_last_out)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Our own copy of the window being collected. Only entries written in the
   // current window are ever read back, so the store needs no clearing.
   logic [PRICE_W-1:0] win_high [WINDOW_DEPTH];
   logic [PRICE_W-1:0] win_low [WINDOW_DEPTH];
   logic               win_kind [WINDOW_DEPTH];
   int unsigned        win_count = 0;
   logic [PRICE_W-1:0] win_max = '0;
   logic [PRICE_W-1:0] win_min = '1;
   logic               win_seen_feature = 1'b0;
   logic               win_dropped = 1'b0;

   // Normalised words that the block owes us, oldest first.
   norm_word_type norm_words_due[$];

   int mismatch_count = 0;
   int words_taken = 0;
   int burst_left = 0;

   // (x - lowest) / (highest - lowest) as signed Q8.16. The magnitude is cut
   // towards zero at 16 fraction bits before the sign goes on, and anything
   // of magnitude 256.0 or more is clamped to the end of the range.
   function automatic logic [NORM_W-1:0] norm_q816(input logic [PRICE_W-1:0] x,
                                                   input logic [PRICE_W-1:0] lowest,
                                                   input logic [PRICE_W-1:0] highest);
      logic        diff_neg;
      logic        span_neg;
      logic [63:0] diff_mag;
      logic [63:0] span_mag;
      logic [63:0] whole;
      logic [63:0] rest;
      logic [63:0] mag;
      logic [63:0] twos;
      diff_neg = x < lowest;
      span_neg = highest < lowest;
      diff_mag = diff_neg ? 64'(lowest - x) : 64'(x - lowest);
      span_mag = span_neg ? 64'(lowest - highest) : 64'(highest - lowest);
      if (span_mag == 0) begin
         return '0;
      end
      whole = diff_mag / span_mag;
      rest  = diff_mag % span_mag;
      if (whole >= 256) begin
         return (diff_neg != span_neg) ? NEG_SAT : POS_SAT;
      end
      mag = (whole << FRAC_BITS) | ((rest << FRAC_BITS) / span_mag);
      if (diff_neg != span_neg) begin
         twos = (64'd1 << NORM_W) - mag;
         return twos[NORM_W-1:0];
      end
      return mag[NORM_W-1:0];
   endfunction

   // Takes one accepted row into the window copy. The row flagged last
   // closes the window and queues one word per stored row.
   task automatic collect_row(input logic [PRICE_W-1:0] high, input logic [PRICE_W-1:0] low,
                              input logic is_target, input logic last_row);
      norm_word_type word;
      logic          flat;
      if (win_count < WINDOW_DEPTH) begin
         win_high[win_count] = high;
         win_low[win_count]  = low;
         win_kind[win_count] = is_target;
         win_count++;
         if (!is_target) begin
            if (high > win_max) win_max = high;
            if (low < win_min) win_min = low;
            win_seen_feature = 1'b1;
         end
      end else begin
         // The store is full: the row is lost but the window remembers it.
         win_dropped = 1'b1;
      end
      if (last_row) begin
         flat = !win_seen_feature || (win_max == win_min);
         for (int k = 0; k < win_count; k++) begin
            word.high_q  = flat ? '0 : norm_q816(win_high[k], win_min, win_max);
            word.low_q   = flat ? '0 : norm_q816(win_low[k], win_min, win_max);
            word.target  = win_kind[k];
            word.flat    = flat;
            word.dropped = win_dropped;
            word.closes  = (k == win_count - 1);
            norm_words_due.push_back(word);
         end
         win_count        = 0;
         win_max          = '0;
         win_min          = '1;
         win_seen_feature = 1'b0;
         win_dropped      = 1'b0;
      end
   endtask

   // Offers one row on the req channel and waits for it to be taken. The
   // sender works in bursts: when a burst runs out, valid may drop before the
   // next one starts. It is entered and left at a falling edge, so valid is
   // never lowered and raised in the same time step.
   task automatic send_row(input logic [PRICE_W-1:0] high, input logic [PRICE_W-1:0] low,
                           input logic is_target, input logic last_row);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_price_high <= high;
      req_price_low  <= low;
      req_is_target  <= is_target;
      req_last_row   <= last_row;
      do @(posedge clock); while (!req_ready);
      collect_row(high, low, is_target, last_row);
      burst_left--;
      @(negedge clock);
   endtask

   // A whole window with random content. A tidy window offsets its highs from
   // a common base by a random spread, takes each low a smaller random amount
   // below its high, and puts its feature rows first and its target rows at
   // the end. A noisy one uses unrelated prices and a random kind on each row.
   task automatic send_random_window(input int rows, input bit noisy);
      logic [PRICE_W-1:0] base;
      logic [PRICE_W-1:0] spread;
      logic [PRICE_W-1:0] high;
      logic [PRICE_W-1:0] low;
      logic               is_target;
      int                 feature_rows;
      case ($urandom_range(0, 2))
         0: begin
            spread = 32'h0000_000F;
         end
         1: begin
            spread = 32'h0000_FFFF;
         end
         default: begin
            spread = 32'hFFFF_FFFF;
         end
      endcase
      base = $urandom;
      feature_rows = rows - $urandom_range(0, (rows + 2) / 3);
      for (int r = 0; r < rows; r++) begin
         if (noisy) begin
            high      = $urandom;
            low       = $urandom;
            is_target = 1'($urandom_range(0, 1));
         end else begin
            high      = base + ($urandom & spread);
            low       = high - ($urandom & (spread >> 2));
            is_target = (r >= feature_rows);
         end
         send_row(high, low, is_target, r == rows - 1);
      end
   endtask

   // The widest possible range, with rows sitting on both ends of it.
   task automatic test_extreme_prices;
      send_row(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      send_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
   endtask

   // Windows of a single row: a flat feature row, a lone target row with no
   // feature row to set the range, and a feature row whose high is 1.0.
   task automatic test_single_rows;
      send_row(32'd1000, 32'd1000, 1'b0, 1'b1);
      send_row(32'd4000, 32'd3000, 1'b1, 1'b1);
      send_row(32'd2000, 32'd1000, 1'b0, 1'b1);
   endtask

   // Feature rows whose highest high equals their lowest low, and a window
   // made of target rows only; both must come back zeroed and flagged.
   task automatic test_flat_range;
      send_row(32'd77, 32'd77, 1'b0, 1'b0);
      send_row(32'd77, 32'd77, 1'b0, 1'b0);
      send_row(32'd500, 32'd3, 1'b1, 1'b1);
      send_row(32'd900, 32'd100, 1'b1, 1'b0);
      send_row(32'd60, 32'd20, 1'b1, 1'b1);
   endtask

   // Feature highs below the feature lows make the range negative, which
   // flips the sign of every quotient.
   task automatic test_inverted_range;
      send_row(32'd100, 32'd200, 1'b0, 1'b0);
      send_row(32'd150, 32'd300, 1'b0, 1'b0);
      send_row(32'd400, 32'd50, 1'b1, 1'b1);
   endtask

   // A range of ten price units: target rows land just inside and exactly on
   // +256.0 and -256.0, far beyond both, and just below the minimum.
   task automatic test_saturation;
      send_row(32'd5010, 32'd5000, 1'b0, 1'b0);
      send_row(32'd5004, 32'd5002, 1'b0, 1'b0);
      send_row(32'd7560, 32'd7559, 1'b1, 1'b0);
      send_row(32'd0, 32'd4999, 1'b1, 1'b0);
      send_row(32'd2441, 32'd2440, 1'b1, 1'b0);
      send_row(32'hFFFF_FFFF, 32'd2440, 1'b1, 1'b1);
   endtask

   // A window that fills the store exactly, then windows that run past it so
   // that rows are dropped; in each of them the closing row itself is lost.
   task automatic test_full_store;
      send_random_window(WINDOW_DEPTH, 1'b0);
      send_random_window(WINDOW_DEPTH + 3, 1'b0);
      send_random_window(WINDOW_DEPTH + 1, 1'b1);
   endtask

   // Mostly short windows, since each row ties up the shared divider; now and
   // then a long one that may overrun the store.
   task automatic test_random_windows;
      int rows_sent;
      int rows;
      int pick;
      rows_sent = 0;
      while (rows_sent < 60) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            rows = $urandom_range(1, 6);
         end else if (pick < 9) begin
            rows = $urandom_range(7, 16);
         end else begin
            rows = $urandom_range(WINDOW_DEPTH - 2, WINDOW_DEPTH + 4);
         end
         send_random_window(rows, $urandom_range(0, 4) == 0);
         rows_sent += rows;
      end
   endtask

   function automatic void note_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", text);
      end
   endfunction

   // The receiver changes its manner at random intervals: taking every
   // word, every other word, most words, or hardly any.
   rx_mode_type rx_mode = RX_STREAM;
   int unsigned rx_left = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 96);
      end else begin
         rx_left = rx_left - 1;
      end
      case (rx_mode)
         RX_STREAM: begin
            rsp_ready <= 1'b1;
         end
         RX_ALTERNATE: begin
            rsp_ready <= ~rsp_ready;
         end
         RX_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // Every word taken from the rsp channel is held against the oldest word
   // still owed; a word that nobody owes is an error in its own right.
   always @(posedge clock) begin
      norm_word_type got;
      norm_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_norm_high, rsp_norm_low, rsp_target_row, rsp_flat_range,
                rsp_overflow, rsp_last_out};
         if (norm_words_due.size() == 0) begin
            note_mismatch($sformatf("rsp word %0d arrived with none owed: %p",
                                    words_taken, got));
         end else begin
            want = norm_words_due.pop_front();
            if (got !== want) begin
               note_mismatch($sformatf({"rsp word %0d: norm_high exp %h got %h, ",
                                        "norm_low exp %h got %h, target exp %b got %b, ",
                                        "flat exp %b got %b, overflow exp %b got %b, ",
                                        "last exp %b got %b"},
                                       words_taken, want.high_q, got.high_q,
                                       want.low_q, got.low_q, want.target, got.target,
                                       want.flat, got.flat, want.dropped, got.dropped,
                                       want.closes, got.closes));
            end
         end
         words_taken++;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extreme_prices();
      test_single_rows();
      test_flat_range();
      test_inverted_range();
      test_saturation();
      test_full_store();
      test_random_windows();
      req_valid <= 1'b0;
      // Every window is closed, so once the last owed word has gone nothing
      // more may appear; a quiet spell afterwards catches stray words.
      while (norm_words_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Far beyond the slowest correct run: about two hundred rows, with the
   // receiver throttled and the sender idling.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
